>>> rtl/dcmt_pkg.sv
// Shared types and constants of the microsecond timebase.
package dcmt_pkg;

    localparam int CPU_WIDTH  = 10;
    localparam int TIME_WIDTH = 64;
    localparam int APB_WIDTH  = 32;
    localparam int ADDR_WIDTH = 3;

    localparam logic [0:0] REG_CYCLES_PER_US = 1'b0;

    typedef struct packed {
        logic load;
        logic step;
        logic add;
        logic out_load;
    } dcmt_cmd_t;

    typedef struct packed {
        logic prime;
    } dcmt_status_t;

endpackage

>>> rtl/dcmt_ctrl.sv
// Controller state machine that sequences request intake, division and result hand-off.
module dcmt_ctrl
    import dcmt_pkg::*;
#(
    parameter int TICK_WIDTH = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  dcmt_status_t status,
    output dcmt_cmd_t    cmd
);

    localparam int DW = ((TICK_WIDTH > CPU_WIDTH) ? TICK_WIDTH : CPU_WIDTH) + 1;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADD,
        ST_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    count_next = '0;
                    state_next = status.prime ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step   = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == LAST_STEP) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> rtl/dcmt_datapath.sv
// Datapath with the timebase state, a bit-serial divider and the result register.
module dcmt_datapath
    import dcmt_pkg::*;
#(
    parameter int TICK_WIDTH = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [TICK_WIDTH-1:0] tick_sample,
    input  logic                  restart,
    input  logic [CPU_WIDTH-1:0]  cycles_per_us,
    input  dcmt_cmd_t             cmd,
    output dcmt_status_t          status,
    output logic [TIME_WIDTH-1:0] time_us,
    output logic                  first_sample
);

    localparam int DW = ((TICK_WIDTH > CPU_WIDTH) ? TICK_WIDTH : CPU_WIDTH) + 1;

    logic                  primed_reg;
    logic [TICK_WIDTH-1:0] last_tick_reg;
    logic [CPU_WIDTH-1:0]  carry_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [CPU_WIDTH-1:0]  div_reg;
    logic [CPU_WIDTH-1:0]  rem_reg;
    logic [DW-1:0]         quo_reg;
    logic                  first_reg;
    logic [TIME_WIDTH-1:0] out_time_reg;
    logic                  out_first_reg;

    logic [TICK_WIDTH-1:0] elapsed;
    logic [DW-1:0]         total;
    logic [CPU_WIDTH:0]    trial;
    logic [CPU_WIDTH:0]    diff;
    logic                  fits;
    logic [CPU_WIDTH-1:0]  rem_next;
    logic [CPU_WIDTH-1:0]  div_eff;

    assign status.prime = restart || !primed_reg;

    assign elapsed = last_tick_reg - tick_sample;
    assign total   = DW'(carry_reg) + DW'(elapsed);
    assign div_eff = (cycles_per_us == '0) ? CPU_WIDTH'(1) : cycles_per_us;

    // One restoring division step: bring down the next dividend bit.
    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign fits     = (trial >= {1'b0, div_reg});
    assign rem_next = fits ? diff[CPU_WIDTH-1:0] : trial[CPU_WIDTH-1:0];

    assign time_us      = out_time_reg;
    assign first_sample = out_first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg    <= 1'b0;
            last_tick_reg <= '0;
            carry_reg     <= '0;
            time_reg      <= '0;
        end else begin
            if (cmd.load) begin
                last_tick_reg <= tick_sample;
                primed_reg    <= 1'b1;
                if (restart) begin
                    carry_reg <= '0;
                    time_reg  <= '0;
                end
            end
            if (cmd.add) begin
                time_reg  <= time_reg + TIME_WIDTH'(quo_reg);
                carry_reg <= rem_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            first_reg <= status.prime;
            div_reg   <= div_eff;
            rem_reg   <= '0;
            quo_reg   <= total;
        end
        if (cmd.step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
        if (cmd.out_load) begin
            out_time_reg  <= time_reg;
            out_first_reg <= first_reg;
        end
    end

endmodule

>>> rtl/downcounter_to_microsecond_timebase.sv
// Top level of the microsecond timebase: ports, configuration register and the two halves.
//
//   Channel   Direction  Moves                          Handshake
//   s_        in         tick sample, restart flag      tvalid / tready
//   m_        out        microsecond time, first flag   tvalid / tready
//   APB       in         cycles_per_us register         psel / penable
//
// A priming request goes from intake straight to the hand-off and skips the
// divider. Any other request passes through intake, one divider step per
// dividend bit (one more than the wider of TICK_WIDTH and cycles_per_us), one
// 64-bit add and the hand-off, in that order. No new request is taken until
// the hand-off is done, and the hand-off waits while the output register is
// still held by m_tready low. Reset clears the state and sets cycles_per_us
// to one.
module downcounter_to_microsecond_timebase
    import dcmt_pkg::*;
#(
    parameter int TICK_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((TICK_WIDTH+7)/8)*8-1:0] s_tdata,  // tick_sample
    input  logic                          s_tuser,  // restart
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TIME_WIDTH-1:0]         m_tdata,  // time_us
    output logic                          m_tuser,  // first_sample
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_WIDTH-1:0]         paddr,
    input  logic [APB_WIDTH-1:0]          pwdata,
    output logic [APB_WIDTH-1:0]          prdata,
    output logic                          pready
);

    logic [CPU_WIDTH-1:0] cpu_reg;
    logic                 cfg_write;
    logic                 cfg_hit;
    dcmt_cmd_t            cmd;
    dcmt_status_t         status;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2:2] == REG_CYCLES_PER_US);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? APB_WIDTH'(cpu_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_reg <= CPU_WIDTH'(1);
        end else if (cfg_write && cfg_hit) begin
            cpu_reg <= pwdata[CPU_WIDTH-1:0];
        end
    end

    dcmt_ctrl #(
        .TICK_WIDTH(TICK_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dcmt_datapath #(
        .TICK_WIDTH(TICK_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_sample   (s_tdata[TICK_WIDTH-1:0]),
        .restart       (s_tuser),
        .cycles_per_us (cpu_reg),
        .cmd           (cmd),
        .status        (status),
        .time_us       (m_tdata),
        .first_sample  (m_tuser)
    );

endmodule
